// ----- rtl/cabm_pkg.sv -----
// Shared types and constants of the cyclic asynchronous buffer manager.
`timescale 1ns / 1ps

package cabm_pkg;

  // Buffer pool size and the index width that the stream fields carry.
  localparam int unsigned NumBuffers  = 8;
  localparam int unsigned IdxW        = 3;
  // Width of the free entry count, which must hold NumBuffers itself.
  localparam int unsigned FreeCntW    = $clog2(NumBuffers + 1);
  // Default width of each reader use count.
  localparam int unsigned CountWidth  = 8;

  localparam int unsigned CmdW        = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 8;

  typedef logic [IdxW-1:0] idx_t;

  // Command codes of an input word.
  typedef enum logic [CmdW-1:0] {
    CMD_RESERVE = 2'd0,
    CMD_PUT     = 2'd1,
    CMD_GET     = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  // Status codes of a result word.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // Read and write control from the command logic to the table memories.
  typedef struct packed {
    logic rd_en;
    idx_t link_raddr;
    idx_t cnt_raddr;
    logic link_we;
    idx_t link_waddr;
    idx_t link_wdata;
    logic cnt_we;
    idx_t cnt_waddr;
  } tbl_ctrl_t;

endpackage

// ----- rtl/cyclic_async_buffer_manager.sv -----
// Top level of the cyclic asynchronous buffer manager.
`timescale 1ns / 1ps

// Hands out buffer indices for a cyclic asynchronous buffer of eight buffers.
// Each input word carries a command (reserve, put, get, release) and a buffer
// index; each command returns exactly one result word with the index handed
// out and a status code. After reset buffers 0 to 6 are free and buffer 7 is
// the most recent message. A command first reads the link table and the
// reader count memories, then modifies and writes back the entry and loads
// the result into the output register. A word is accepted only after the last
// command finishes, which needs a free output register. A new word may be
// accepted while the previous result still waits.
module cyclic_async_buffer_manager #(
  parameter int unsigned COUNT_WIDTH = cabm_pkg::CountWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0 up: cmd [1:0], buf_index [4:2], zero fill [7:5].
  input  logic [cabm_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: result_index [2:0], status [4:3], zero fill [7:5].
  output logic [cabm_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam logic [cabm_pkg::FreeCntW-1:0] FreeFull =
    cabm_pkg::FreeCntW'(cabm_pkg::NumBuffers);
  localparam logic [cabm_pkg::FreeCntW-1:0] FreeInit =
    cabm_pkg::FreeCntW'(cabm_pkg::NumBuffers - 1);
  localparam cabm_pkg::idx_t RecentInit = cabm_pkg::IdxW'(cabm_pkg::NumBuffers - 1);

  logic                           busy_q, busy_d;
  cabm_pkg::cmd_e                 cmd_q;
  cabm_pkg::idx_t                 idx_q;
  cabm_pkg::idx_t                 free_head_q, free_head_d;
  logic [cabm_pkg::FreeCntW-1:0]  free_cnt_q, free_cnt_d;
  cabm_pkg::idx_t                 recent_q, recent_d;
  logic                           out_valid_q, out_valid_d;
  cabm_pkg::idx_t                 out_idx_q, out_idx_d;
  cabm_pkg::status_e              out_status_q, out_status_d;

  cabm_pkg::tbl_ctrl_t            ctrl;
  logic [COUNT_WIDTH-1:0]         cnt_wdata;
  cabm_pkg::idx_t                 link_rdata;
  logic [COUNT_WIDTH-1:0]         cnt_rdata;

  logic                           in_fire;
  logic                           finish;
  cabm_pkg::cmd_e                 in_cmd;
  cabm_pkg::idx_t                 in_idx;
  logic                           push_en;
  cabm_pkg::idx_t                 push_idx;

  assign in_cmd = cabm_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_idx = s_axis_tdata[4:2];

  // One command in flight; its result needs a free output register.
  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign finish        = busy_q && (!out_valid_q || m_axis_tready);

  cabm_tables #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tables (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cnt_wdata_i  (cnt_wdata),
    .link_rdata_o (link_rdata),
    .cnt_rdata_o  (cnt_rdata)
  );

  // Command execution: read data arrives in the cycle after acceptance.
  always_comb begin
    busy_d       = busy_q;
    free_head_d  = free_head_q;
    free_cnt_d   = free_cnt_q;
    recent_d     = recent_q;
    out_valid_d  = out_valid_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    push_en      = 1'b0;
    push_idx     = recent_q;
    cnt_wdata    = cnt_rdata;

    ctrl            = '0;
    ctrl.rd_en      = in_fire;
    ctrl.link_raddr = free_head_q;
    ctrl.cnt_raddr  = (in_cmd == cabm_pkg::CMD_RELEASE) ? in_idx : recent_q;
    ctrl.cnt_waddr  = recent_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      busy_d = 1'b1;
    end

    if (finish) begin
      busy_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_idx_d    = '0;
      out_status_d = cabm_pkg::ST_OK;
      case (cmd_q)
        cabm_pkg::CMD_RESERVE: begin
          if (free_cnt_q == '0) begin
            out_status_d = cabm_pkg::ST_EMPTY;
          end else begin
            out_idx_d   = free_head_q;
            free_head_d = link_rdata;
            free_cnt_d  = free_cnt_q - 1'b1;
          end
        end
        cabm_pkg::CMD_PUT: begin
          push_en  = (cnt_rdata == '0);
          push_idx = recent_q;
          recent_d = idx_q;
        end
        cabm_pkg::CMD_GET: begin
          if (cnt_rdata == '1) begin
            out_status_d = cabm_pkg::ST_OVERFLOW;
          end else begin
            ctrl.cnt_we    = 1'b1;
            ctrl.cnt_waddr = recent_q;
            cnt_wdata      = cnt_rdata + 1'b1;
            out_idx_d      = recent_q;
          end
        end
        cabm_pkg::CMD_RELEASE: begin
          if (cnt_rdata == '0) begin
            out_status_d = cabm_pkg::ST_UNDERFLOW;
          end else begin
            ctrl.cnt_we    = 1'b1;
            ctrl.cnt_waddr = idx_q;
            cnt_wdata      = cnt_rdata - 1'b1;
            push_en        = (cnt_rdata == COUNT_WIDTH'(1)) && (idx_q != recent_q);
            push_idx       = idx_q;
          end
        end
        default: begin
          out_status_d = cabm_pkg::ST_OK;
        end
      endcase

      // Push onto the free list head unless the list already holds every buffer.
      if (push_en && (free_cnt_q < FreeFull)) begin
        ctrl.link_we    = 1'b1;
        ctrl.link_waddr = push_idx;
        ctrl.link_wdata = free_head_q;
        free_head_d     = push_idx;
        free_cnt_d      = free_cnt_q + 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      free_head_q <= '0;
      free_cnt_q  <= FreeInit;
      recent_q    <= RecentInit;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      recent_q    <= recent_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_cmd;
      idx_q <= in_idx;
    end
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_status_q, out_idx_q};

`ifndef ASSERT_OFF
  // The free list never counts more entries than there are buffers.
  a_free_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= FreeFull)
    else $error("free list count exceeds the buffer pool");

  // An accepted word is held for execution in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q)
    else $error("accepted word not taken into execution");

  // A finished command always leaves a result in the output register.
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && !busy_q))
    else $error("finished command produced no result word");

  // A successful reserve hands out the old free head.
  a_reserve_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (cmd_q == cabm_pkg::CMD_RESERVE) && (free_cnt_q != '0))
      |=> (out_idx_q == $past(free_head_q)) && (free_cnt_q == $past(free_cnt_q) - 1'b1))
    else $error("reserve did not pop the free list head");
`endif

endmodule

// ----- rtl/cabm_tables.sv -----
// Link table and reader count memories with reset-value tracking.
`timescale 1ns / 1ps

module cabm_tables #(
  parameter int unsigned COUNT_WIDTH = cabm_pkg::CountWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cabm_pkg::tbl_ctrl_t     ctrl_i,
  input  logic [COUNT_WIDTH-1:0]  cnt_wdata_i,
  output cabm_pkg::idx_t          link_rdata_o,
  output logic [COUNT_WIDTH-1:0]  cnt_rdata_o
);

  // Storage without reset; the valid bits stand in for the reset contents.
  cabm_pkg::idx_t           link_mem [cabm_pkg::NumBuffers];
  logic [COUNT_WIDTH-1:0]   cnt_mem  [cabm_pkg::NumBuffers];

  logic [cabm_pkg::NumBuffers-1:0] link_vld_q, link_vld_d;
  logic [cabm_pkg::NumBuffers-1:0] cnt_vld_q, cnt_vld_d;

  cabm_pkg::idx_t           link_raw_q;
  logic [COUNT_WIDTH-1:0]   cnt_raw_q;
  logic                     link_rvld_q;
  logic                     cnt_rvld_q;
  cabm_pkg::idx_t           link_raddr_q;

  // Memory write and registered read ports.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.link_we) begin
      link_mem[ctrl_i.link_waddr] <= ctrl_i.link_wdata;
    end
    if (ctrl_i.cnt_we) begin
      cnt_mem[ctrl_i.cnt_waddr] <= cnt_wdata_i;
    end
    if (ctrl_i.rd_en) begin
      link_raw_q   <= link_mem[ctrl_i.link_raddr];
      cnt_raw_q    <= cnt_mem[ctrl_i.cnt_raddr];
      link_raddr_q <= ctrl_i.link_raddr;
    end
  end

  // Valid bits are set by the first write to an entry.
  always_comb begin
    link_vld_d = link_vld_q;
    cnt_vld_d  = cnt_vld_q;
    if (ctrl_i.link_we) begin
      link_vld_d[ctrl_i.link_waddr] = 1'b1;
    end
    if (ctrl_i.cnt_we) begin
      cnt_vld_d[ctrl_i.cnt_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q  <= '0;
      cnt_vld_q   <= '0;
      link_rvld_q <= 1'b0;
      cnt_rvld_q  <= 1'b0;
    end else begin
      link_vld_q <= link_vld_d;
      cnt_vld_q  <= cnt_vld_d;
      if (ctrl_i.rd_en) begin
        link_rvld_q <= link_vld_q[ctrl_i.link_raddr];
        cnt_rvld_q  <= cnt_vld_q[ctrl_i.cnt_raddr];
      end
    end
  end

  // An unwritten link entry reads as the next index; an unwritten count as zero.
  assign link_rdata_o = link_rvld_q ? link_raw_q : cabm_pkg::IdxW'(link_raddr_q + 1'b1);
  assign cnt_rdata_o  = cnt_rvld_q ? cnt_raw_q : '0;

endmodule
